// File: src/tcw_pkg.sv
// ============================================================================
// tcw_pkg
// Types and constants shared by the text console writer core and its
// cursor step unit.
// ============================================================================
package tcw_pkg;

    // command codes
    localparam logic [1:0] CMD_PUT      = 2'd0;
    localparam logic [1:0] CMD_MOVE_PUT = 2'd1;
    localparam logic [1:0] CMD_CLEAR    = 2'd2;
    localparam logic [1:0] CMD_READ     = 2'd3;

    // character codes with special handling
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] CH_NEWLINE   = 8'h0A;
    localparam logic [7:0] CH_BACKSPACE = 8'h08;

    localparam logic [7:0] ATTR_RESET   = 8'd15;

    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] char_code;
        logic [6:0] column;
        logic [4:0] row;
    } t_cmd_item;

    typedef struct packed {
        logic [6:0] cursor_column;
        logic [4:0] cursor_row;
        logic [7:0] cell_char;
        logic [7:0] cell_attr;
        logic       scrolled;
    } t_result_item;

    typedef struct packed {
        logic wr_en;
        logic scroll;
    } t_step_flags;

endpackage

// File: src/tcw_cursor_step.sv
// ============================================================================
// tcw_cursor_step
// Works out, for one character at a given cursor position, which cell is
// written, the new cursor and whether the screen has to scroll.
// ============================================================================
module tcw_cursor_step #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic [$clog2(COLUMNS)-1:0] i_col,
    input  logic [$clog2(ROWS)-1:0]    i_row,
    input  logic [7:0]                 i_char,
    output logic [$clog2(COLUMNS)-1:0] o_col,
    output logic [$clog2(ROWS)-1:0]    o_row,
    output logic [$clog2(COLUMNS)-1:0] o_wr_col,
    output logic [$clog2(ROWS)-1:0]    o_wr_row,
    output logic [7:0]                 o_wr_char,
    output tcw_pkg::t_step_flags       o_flags
);
    import tcw_pkg::*;

    localparam int CW = $clog2(COLUMNS);
    localparam int RW = $clog2(ROWS);

    logic last_col;
    logic last_row;

    assign last_col = (i_col == CW'(COLUMNS - 1));
    assign last_row = (i_row == RW'(ROWS - 1));

    always_comb begin
        o_col          = i_col;
        o_row          = i_row;
        o_wr_col       = i_col;
        o_wr_row       = i_row;
        o_wr_char      = i_char;
        o_flags.wr_en  = 1'b0;
        o_flags.scroll = 1'b0;
        if (i_char == CH_NEWLINE) begin
            o_col = '0;
            if (last_row) begin
                o_flags.scroll = 1'b1;
            end else begin
                o_row = i_row + RW'(1);
            end
        end else if (i_char == CH_BACKSPACE) begin
            // at the origin nothing changes
            if (i_col != '0) begin
                o_col         = i_col - CW'(1);
                o_flags.wr_en = 1'b1;
            end else if (i_row != '0) begin
                o_col         = CW'(COLUMNS - 1);
                o_row         = i_row - RW'(1);
                o_flags.wr_en = 1'b1;
            end
            o_wr_col  = o_col;
            o_wr_row  = o_row;
            o_wr_char = CH_SPACE;
        end else begin
            o_flags.wr_en = 1'b1;
            if (last_col) begin
                o_col = '0;
                if (last_row) begin
                    o_flags.scroll = 1'b1;
                end else begin
                    o_row = i_row + RW'(1);
                end
            end else begin
                o_col = i_col + CW'(1);
            end
        end
    end

endmodule

// File: src/text_console_writer_core.sv
// ============================================================================
// text_console_writer_core
// Text console engine: cell store, cursor, character commands, scroll and
// clear, all through one cell store port pair and one address unit.
// ============================================================================
// A clear and a put that scrolls take longer than the other commands: they sweep
// the whole cell store, one cell a cycle through the single store write port.
// A new command is taken in the cycle o_done is high; busy is high until then.
// After reset the store is swept to zero with busy high.
// o_done is high for one cycle and the receiver cannot stall.
module text_console_writer_core #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   start,
    output logic                   busy,
    input  tcw_pkg::t_cmd_item     i_cmd,
    output logic                   o_done,
    output tcw_pkg::t_result_item  o_result,
    input  logic                   i_cfg_we,
    input  logic [7:0]             i_cfg_data
);
    import tcw_pkg::*;

    localparam int CELLS = COLUMNS * ROWS;
    localparam int AW    = $clog2(CELLS);
    localparam int CW    = $clog2(COLUMNS);
    localparam int RW    = $clog2(ROWS);

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_EXEC,
        S_READ,
        S_CLEAR,
        S_SCROLL,
        S_DRAIN
    } t_state;

    t_state        r_state;
    logic [AW-1:0] r_idx;
    logic [CW-1:0] r_ccol;
    logic [RW-1:0] r_crow;
    logic [7:0]    r_attr;
    logic          r_done;
    t_result_item  r_result;

    // registered command
    logic [1:0]    r_cmd;
    logic [7:0]    r_char;
    logic [CW-1:0] r_tcol;
    logic [RW-1:0] r_trow;

    // pending write of the scroll copy
    logic          r_wp_en;
    logic [AW-1:0] r_wp_addr;
    logic          r_wp_zero;

    logic [15:0]   r_mem [CELLS];
    logic [15:0]   r_rd_data;

    logic [CW-1:0] clamp_col;
    logic [RW-1:0] clamp_row;
    logic [CW-1:0] pos_col;
    logic [RW-1:0] pos_row;
    logic [CW-1:0] step_col;
    logic [RW-1:0] step_row;
    logic [CW-1:0] step_wr_col;
    logic [RW-1:0] step_wr_row;
    logic [7:0]    step_wr_char;
    t_step_flags   step_flags;

    logic [CW-1:0] a_col;
    logic [RW-1:0] a_row;
    logic [AW-1:0] cell_addr;
    logic          idx_last;

    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [15:0]   wr_data;
    logic [AW-1:0] rd_addr;

    assign clamp_col = (32'(i_cmd.column) >= COLUMNS) ? CW'(COLUMNS - 1) : CW'(i_cmd.column);
    assign clamp_row = (32'(i_cmd.row) >= ROWS) ? RW'(ROWS - 1) : RW'(i_cmd.row);

    assign pos_col = (r_cmd == CMD_MOVE_PUT) ? r_tcol : r_ccol;
    assign pos_row = (r_cmd == CMD_MOVE_PUT) ? r_trow : r_crow;

    tcw_cursor_step #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_step (
        .i_col     (pos_col),
        .i_row     (pos_row),
        .i_char    (r_char),
        .o_col     (step_col),
        .o_row     (step_row),
        .o_wr_col  (step_wr_col),
        .o_wr_row  (step_wr_row),
        .o_wr_char (step_wr_char),
        .o_flags   (step_flags)
    );

    // shared address unit: row * COLUMNS + column
    assign a_col     = (r_cmd == CMD_READ) ? r_tcol : step_wr_col;
    assign a_row     = (r_cmd == CMD_READ) ? r_trow : step_wr_row;
    assign cell_addr = AW'(a_row) * AW'(COLUMNS) + AW'(a_col);

    assign idx_last = (r_idx == AW'(CELLS - 1));

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = cell_addr;
        wr_data = {r_attr, step_wr_char};
        if (r_wp_en) begin
            wr_en   = 1'b1;
            wr_addr = r_wp_addr;
            wr_data = r_wp_zero ? 16'h0000 : r_rd_data;
        end else begin
            case (r_state)
                S_INIT: begin
                    wr_en   = 1'b1;
                    wr_addr = r_idx;
                    wr_data = 16'h0000;
                end
                S_CLEAR: begin
                    wr_en   = 1'b1;
                    wr_addr = r_idx;
                    wr_data = {r_attr, CH_SPACE};
                end
                S_EXEC: begin
                    wr_en = ((r_cmd == CMD_PUT) || (r_cmd == CMD_MOVE_PUT)) && step_flags.wr_en;
                end
                default: begin
                    wr_en = 1'b0;
                end
            endcase
        end
    end

    // scroll reads one row ahead of the write
    assign rd_addr = (r_state == S_SCROLL) ? (r_idx + AW'(COLUMNS)) : cell_addr;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rd_data <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_idx   <= '0;
            r_ccol  <= '0;
            r_crow  <= '0;
            r_attr  <= ATTR_RESET;
            r_done  <= 1'b0;
            r_wp_en <= 1'b0;
        end else begin
            r_done  <= 1'b0;
            r_wp_en <= 1'b0;
            if (i_cfg_we) begin
                r_attr <= i_cfg_data;
            end
            case (r_state)
                S_INIT: begin
                    if (idx_last) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_idx <= r_idx + AW'(1);
                    end
                end
                S_IDLE: begin
                    if (start) begin
                        r_cmd   <= i_cmd.cmd;
                        r_char  <= i_cmd.char_code;
                        r_tcol  <= clamp_col;
                        r_trow  <= clamp_row;
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    case (r_cmd)
                        CMD_CLEAR: begin
                            r_idx   <= '0;
                            r_state <= S_CLEAR;
                        end
                        CMD_READ: begin
                            r_state <= S_READ;
                        end
                        default: begin
                            r_ccol <= step_col;
                            r_crow <= step_row;
                            if (step_flags.scroll) begin
                                r_idx   <= '0;
                                r_state <= S_SCROLL;
                            end else begin
                                r_done   <= 1'b1;
                                r_result <= '{cursor_column: 7'(step_col),
                                              cursor_row:    5'(step_row),
                                              cell_char:     8'h00,
                                              cell_attr:     8'h00,
                                              scrolled:      1'b0};
                                r_state  <= S_IDLE;
                            end
                        end
                    endcase
                end
                S_READ: begin
                    r_done   <= 1'b1;
                    r_result <= '{cursor_column: 7'(r_ccol),
                                  cursor_row:    5'(r_crow),
                                  cell_char:     r_rd_data[7:0],
                                  cell_attr:     r_rd_data[15:8],
                                  scrolled:      1'b0};
                    r_state  <= S_IDLE;
                end
                S_CLEAR: begin
                    if (idx_last) begin
                        r_ccol   <= '0;
                        r_crow   <= '0;
                        r_done   <= 1'b1;
                        r_result <= '{cursor_column: 7'd0,
                                      cursor_row:    5'd0,
                                      cell_char:     8'h00,
                                      cell_attr:     8'h00,
                                      scrolled:      1'b0};
                        r_state  <= S_IDLE;
                    end else begin
                        r_idx <= r_idx + AW'(1);
                    end
                end
                S_SCROLL: begin
                    // bottom row is filled with zero cells
                    r_wp_en   <= 1'b1;
                    r_wp_addr <= r_idx;
                    r_wp_zero <= (r_idx >= AW'(CELLS - COLUMNS));
                    if (idx_last) begin
                        r_state <= S_DRAIN;
                    end else begin
                        r_idx <= r_idx + AW'(1);
                    end
                end
                S_DRAIN: begin
                    r_done   <= 1'b1;
                    r_result <= '{cursor_column: 7'(r_ccol),
                                  cursor_row:    5'(r_crow),
                                  cell_char:     8'h00,
                                  cell_attr:     8'h00,
                                  scrolled:      1'b1};
                    r_state  <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign busy     = (r_state != S_IDLE);
    assign o_done   = r_done;
    assign o_result = r_result;

    a_done_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> (r_state == S_IDLE))
        else $error("result strobe outside idle state");

    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (32'(r_ccol) < COLUMNS) && (32'(r_crow) < ROWS))
        else $error("cursor out of range");

    a_scroll_bottom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_done && r_result.scrolled) |-> (32'(r_crow) == ROWS - 1))
        else $error("scroll did not leave cursor on bottom row");

    a_pending_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wp_en |-> ((r_state == S_SCROLL) || (r_state == S_DRAIN)))
        else $error("copy write outside scroll sweep");

    a_read_keeps_cursor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ) |=> ($stable(r_ccol) && $stable(r_crow)))
        else $error("cell read moved the cursor");

endmodule

// File: tb/sv/tb_text_console_writer_core.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_text_console_writer_core
// Self-checking bench for the text console writer core. A scoreboard class
// keeps a mirror of the cell store, cursor and attribute register, predicts
// the result of each accepted command and checks every o_done transfer
// against it. A directed run covers wraps, backspace corners, scrolls,
// saturated coordinates and clear; random phases follow at three attribute
// settings and three sender idle rates.
// ============================================================================
module tb_text_console_writer_core;
    import tcw_pkg::*;

    localparam int COLUMNS        = 80;
    localparam int ROWS           = 25;
    localparam int CELL_COUNT     = COLUMNS * ROWS;
    localparam int PHASE_ITEMS    = 550;
    // a scroll or clear sweeps every cell with no transfer at all
    localparam int WATCHDOG_LIMIT = 25000;

    class console_scoreboard;
        logic [15:0]  cells [CELL_COUNT];
        int unsigned  cursor;
        logic [7:0]   attribute;
        t_result_item awaited_results [$];
        int           fail_count;

        function new();
            foreach (cells[i]) cells[i] = '0;
            cursor     = 0;
            attribute  = ATTR_RESET;
            fail_count = 0;
        endfunction

        function void set_attribute(logic [7:0] value);
            attribute = value;
        endfunction

        function int pending();
            return awaited_results.size();
        endfunction

        function void note_failure(string msg);
            fail_count++;
            if (fail_count <= 10) $display("[%0t] mismatch: %s", $realtime, msg);
        endfunction

        function int unsigned clamped_cell(logic [6:0] column, logic [4:0] row);
            int unsigned c;
            int unsigned r;
            c = (column >= COLUMNS) ? COLUMNS - 1 : column;
            r = (row >= ROWS) ? ROWS - 1 : row;
            return r * COLUMNS + c;
        endfunction

        function void scroll_cells();
            for (int i = 0; i < CELL_COUNT - COLUMNS; i++) cells[i] = cells[i + COLUMNS];
            for (int i = CELL_COUNT - COLUMNS; i < CELL_COUNT; i++) cells[i] = '0;
        endfunction

        // apply one command to the mirror and queue the result it yields
        function void note_command(t_cmd_item c);
            t_result_item r;
            int unsigned  pos;
            int unsigned  idx;
            r   = '0;
            pos = (cursor >= CELL_COUNT) ? 0 : cursor;
            case (c.cmd)
                CMD_CLEAR: begin
                    foreach (cells[i]) cells[i] = {attribute, CH_SPACE};
                    pos = 0;
                end
                CMD_READ: begin
                    idx         = clamped_cell(c.column, c.row);
                    r.cell_char = cells[idx][7:0];
                    r.cell_attr = cells[idx][15:8];
                end
                default: begin
                    if (c.cmd == CMD_MOVE_PUT) pos = clamped_cell(c.column, c.row);
                    if (c.char_code == CH_NEWLINE) begin
                        pos = (pos / COLUMNS + 1) * COLUMNS;
                    end else if (c.char_code == CH_BACKSPACE) begin
                        // nothing happens at the origin
                        if (pos > 0) begin
                            pos--;
                            cells[pos] = {attribute, CH_SPACE};
                        end
                    end else begin
                        cells[pos] = {attribute, c.char_code};
                        pos++;
                    end
                    if (pos >= CELL_COUNT) begin
                        scroll_cells();
                        pos -= COLUMNS;
                        r.scrolled = 1'b1;
                    end
                end
            endcase
            cursor          = pos;
            r.cursor_column = 7'(pos % COLUMNS);
            r.cursor_row    = 5'(pos / COLUMNS);
            awaited_results.push_back(r);
        endfunction

        function void check_result(t_result_item got);
            t_result_item want;
            if (awaited_results.size() == 0) begin
                note_failure($sformatf("result with none pending: col %0d row %0d",
                                       got.cursor_column, got.cursor_row));
                return;
            end
            want = awaited_results.pop_front();
            if (got.cursor_column !== want.cursor_column || got.cursor_row !== want.cursor_row
                || got.cell_char !== want.cell_char || got.cell_attr !== want.cell_attr
                || got.scrolled !== want.scrolled) begin
                note_failure($sformatf(
                    "exp col %0d row %0d char %h attr %h scr %b, got col %0d row %0d char %h attr %h scr %b",
                    want.cursor_column, want.cursor_row, want.cell_char, want.cell_attr,
                    want.scrolled, got.cursor_column, got.cursor_row, got.cell_char,
                    got.cell_attr, got.scrolled));
            end
        endfunction
    endclass

    logic         i_clk      = 1'b0;
    logic         i_rst_n    = 1'b0;
    logic         start      = 1'b0;
    logic         busy;
    t_cmd_item    i_cmd      = '0;
    logic         o_done;
    t_result_item o_result;
    logic         i_cfg_we   = 1'b0;
    logic [7:0]   i_cfg_data = '0;
    int           quiet_cycles = 0;

    console_scoreboard sb = new();

    text_console_writer_core #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_cmd      (i_cmd),
        .o_done     (o_done),
        .o_result   (o_result),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (o_done) sb.check_result(o_result);
    end

    always @(posedge i_clk) begin
        if ((start && !busy) || o_done) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    function automatic t_cmd_item make_cmd(logic [1:0] cmd, logic [7:0] ch,
                                           logic [6:0] column, logic [4:0] row);
        t_cmd_item c;
        c.cmd       = cmd;
        c.char_code = ch;
        c.column    = column;
        c.row       = row;
        return c;
    endfunction

    function automatic logic [7:0] random_char();
        int pick;
        pick = $urandom_range(99);
        if (pick < 10) return CH_NEWLINE;
        if (pick < 18) return CH_BACKSPACE;
        return 8'($urandom_range(255));
    endfunction

    // coordinates: in range, edges, the bottom row, or any bit pattern
    function automatic t_cmd_item with_random_spot(t_cmd_item c);
        int pick;
        pick = $urandom_range(3);
        case (pick)
            0: begin
                c.column = 7'($urandom_range(127));
                c.row    = 5'($urandom_range(31));
            end
            1: begin
                c.column = 7'($urandom_range(COLUMNS - 1));
                c.row    = 5'($urandom_range(ROWS - 1));
            end
            2: begin
                case ($urandom_range(2))
                    0:       c.column = '0;
                    1:       c.column = 7'(COLUMNS - 1);
                    default: c.column = 7'($urandom_range(127, COLUMNS));
                endcase
                case ($urandom_range(2))
                    0:       c.row = '0;
                    1:       c.row = 5'(ROWS - 1);
                    default: c.row = 5'($urandom_range(31, ROWS));
                endcase
            end
            default: begin
                c.column = 7'($urandom_range(COLUMNS - 1));
                c.row    = 5'(ROWS - 1);
            end
        endcase
        return c;
    endfunction

    function automatic t_cmd_item random_command();
        t_cmd_item c;
        int        pick;
        c.char_code = random_char();
        c.column    = 7'($urandom_range(127));
        c.row       = 5'($urandom_range(31));
        pick        = $urandom_range(99);
        if (pick < 2) begin
            c.cmd = CMD_CLEAR;
        end else if (pick < 22) begin
            c.cmd = CMD_READ;
            c     = with_random_spot(c);
        end else if (pick < 40) begin
            c.cmd = CMD_MOVE_PUT;
            c     = with_random_spot(c);
        end else begin
            c.cmd = CMD_PUT;
        end
        return c;
    endfunction

    task automatic send_command(input t_cmd_item item, input int idle_pct);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start <= 1'b1;
        i_cmd <= item;
        do @(posedge i_clk); while (busy);
        sb.note_command(item);
    endtask

    task automatic write_attribute(input logic [7:0] value);
        start <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        sb.set_attribute(value);
        i_cfg_we   <= 1'b0;
    endtask

    task automatic run_random(input int count, input int idle_pct);
        for (int n = 0; n < count; n++) send_command(random_command(), idle_pct);
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: reset contents, backspace corners, wraps, scrolls, clear
        send_command(make_cmd(CMD_READ, 8'hFF, 7'd0, 5'd0), 0);
        send_command(make_cmd(CMD_PUT, "A", 7'd0, 5'd0), 0);
        send_command(make_cmd(CMD_READ, 8'h00, 7'd0, 5'd0), 0);
        send_command(make_cmd(CMD_PUT, CH_BACKSPACE, 7'd0, 5'd0), 0);
        send_command(make_cmd(CMD_PUT, CH_BACKSPACE, 7'd0, 5'd0), 0);
        send_command(make_cmd(CMD_MOVE_PUT, "Z", 7'd127, 5'd31), 0);
        send_command(make_cmd(CMD_READ, 8'h00, 7'd79, 5'd23), 0);
        send_command(make_cmd(CMD_READ, 8'h00, 7'd127, 5'd31), 0);
        send_command(make_cmd(CMD_MOVE_PUT, CH_BACKSPACE, 7'd0, 5'd5), 0);
        send_command(make_cmd(CMD_READ, 8'h00, 7'd79, 5'd4), 0);
        send_command(make_cmd(CMD_PUT, CH_NEWLINE, 7'd127, 5'd31), 0);
        send_command(make_cmd(CMD_MOVE_PUT, CH_NEWLINE, 7'd40, 5'd24), 0);
        send_command(make_cmd(CMD_PUT, 8'hFF, 7'd0, 5'd0), 0);
        send_command(make_cmd(CMD_PUT, 8'h00, 7'd0, 5'd0), 0);
        send_command(make_cmd(CMD_MOVE_PUT, "x", 7'd79, 5'd10), 0);
        send_command(make_cmd(CMD_READ, 8'h00, 7'd79, 5'd10), 0);
        send_command(make_cmd(CMD_MOVE_PUT, "y", 7'd80, 5'd0), 0);
        send_command(make_cmd(CMD_CLEAR, 8'hFF, 7'd127, 5'd31), 0);
        send_command(make_cmd(CMD_READ, 8'h00, 7'd0, 5'd0), 0);
        send_command(make_cmd(CMD_READ, 8'hFF, 7'd80, 5'd25), 0);
        send_command(make_cmd(CMD_PUT, CH_BACKSPACE, 7'd0, 5'd0), 0);

        write_attribute(8'h00);
        send_command(make_cmd(CMD_MOVE_PUT, "q", 7'd79, 5'd24), 0);
        send_command(make_cmd(CMD_READ, 8'h00, 7'd79, 5'd23), 0);
        run_random(PHASE_ITEMS, 18);

        write_attribute(8'hFF);
        send_command(make_cmd(CMD_CLEAR, 8'h00, 7'd0, 5'd0), 0);
        run_random(PHASE_ITEMS, 80);

        write_attribute(8'($urandom_range(1, 254)));
        run_random(PHASE_ITEMS, 0);

        start <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (sb.fail_count == 0 && sb.pending() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
